[src/watchdog_interval_timer_assert.svh]
// Assertion macros for the watchdog interval timer.
// Used by the top level only; needs no package.
`ifndef WATCHDOG_INTERVAL_TIMER_ASSERT_SVH
`define WATCHDOG_INTERVAL_TIMER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define WIT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define WIT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/wit_pkg.sv]
// Shared types, constants and helpers for the watchdog interval timer.
// No dependencies.
`default_nettype none

package wit_pkg;

   typedef enum logic [2:0] {
      CMD_WRITE = 3'd0,
      CMD_READ  = 3'd1,
      CMD_TICK  = 3'd2,
      CMD_PIN   = 3'd3,
      CMD_ACK   = 3'd4,
      CMD_PUC   = 3'd5
   } cmd_type;

   localparam logic [7:0]  PASSWORD  = 8'h5a;
   localparam logic [15:0] READ_BASE = 16'h6900;

   // control byte bit positions
   localparam int unsigned CTL_HOLD  = 7;
   localparam int unsigned CTL_NMIES = 6;
   localparam int unsigned CTL_NMI   = 5;
   localparam int unsigned CTL_TMSEL = 4;
   localparam int unsigned CTL_CNTCL = 3;
   localparam int unsigned CTL_SSEL  = 2;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] wdata;
      logic        tick_source;
      logic        pin_level;
   } item_type;

   typedef struct packed {
      logic [7:0]  control;
      logic [15:0] counter;
      logic        pin;
      logic        irq;
   } state_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        irq_level;
      logic        nmi_pulse;
      logic        puc_pulse;
      logic        sys_reset_pulse;
   } result_type;

   function automatic logic [15:0] interval_len(input logic [1:0] sel);
      logic [15:0] len;
      case (sel)
         2'd0:    len = 16'd32768;
         2'd1:    len = 16'd8192;
         2'd2:    len = 16'd512;
         default: len = 16'd64;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

[src/wit_step.sv]
// Single-pass next-state and result logic for one request.
// Depends on wit_pkg.
`default_nettype none

module wit_step (
   input  wit_pkg::item_type   item,
   input  wit_pkg::state_type  cur,
   output wit_pkg::state_type  nxt,
   output wit_pkg::result_type res
);

   logic [7:0]  new_ctl;
   logic [15:0] cnt_wr;
   logic [15:0] cnt_inc;
   logic        old_es;
   logic        new_es;
   logic        rising;
   logic        falling;

   assign new_ctl = item.wdata[7:0];
   assign old_es  = cur.control[wit_pkg::CTL_NMIES];
   assign new_es  = new_ctl[wit_pkg::CTL_NMIES];
   assign cnt_wr  = new_ctl[wit_pkg::CTL_CNTCL] ? 16'd0 : cur.counter;
   assign cnt_inc = 16'(cur.counter + 16'd1);
   assign rising  = !cur.pin && item.pin_level;
   assign falling = cur.pin && !item.pin_level;

   always_comb begin
      nxt = cur;
      res = '0;
      case (item.cmd)
         wit_pkg::CMD_WRITE: begin
            nxt.control = new_ctl;
            nxt.control[wit_pkg::CTL_CNTCL] = 1'b0;
            nxt.counter = cnt_wr;
            res.puc_pulse = item.wdata[15:8] != wit_pkg::PASSWORD;
            res.nmi_pulse = new_ctl[wit_pkg::CTL_NMI] &&
                            ((cur.pin && !old_es && new_es) ||
                             (!cur.pin && old_es && !new_es));
            // expire at once if the bit at the new interval is already set
            if ((wit_pkg::interval_len(new_ctl[1:0]) & cnt_wr) != 16'd0) begin
               nxt.irq = 1'b1;
               if (!new_ctl[wit_pkg::CTL_TMSEL]) begin
                  res.puc_pulse = 1'b1;
               end
            end
         end
         wit_pkg::CMD_READ: begin
            res.read_data = wit_pkg::READ_BASE | {8'd0, cur.control};
         end
         wit_pkg::CMD_TICK: begin
            if (!cur.control[wit_pkg::CTL_HOLD] &&
                item.tick_source == cur.control[wit_pkg::CTL_SSEL]) begin
               nxt.counter = cnt_inc;
               if ((cnt_inc & 16'(wit_pkg::interval_len(cur.control[1:0]) - 16'd1))
                   == 16'd0) begin
                  nxt.irq = 1'b1;
                  res.puc_pulse = !cur.control[wit_pkg::CTL_TMSEL];
               end
            end
         end
         wit_pkg::CMD_PIN: begin
            if (cur.control[wit_pkg::CTL_NMI]) begin
               res.nmi_pulse = cur.control[wit_pkg::CTL_NMIES] ? falling : rising;
            end else begin
               res.sys_reset_pulse = !item.pin_level;
            end
            nxt.pin = item.pin_level;
         end
         wit_pkg::CMD_ACK: begin
            if (cur.control[wit_pkg::CTL_TMSEL]) begin
               nxt.irq = 1'b0;
            end
         end
         wit_pkg::CMD_PUC: begin
            if (item.pin_level) begin
               nxt.control = 8'd0;
               nxt.counter = 16'd0;
               res.sys_reset_pulse = !cur.pin;
            end
         end
         default: begin
         end
      endcase
      res.irq_level = nxt.irq;
   end

endmodule

`default_nettype wire

[src/watchdog_interval_timer.sv]
// Watchdog / interval timer: a request is held in the input register,
// is evaluated against the timer state in a single pass, and its response
// lands in the output register. One request is accepted every cycle while
// responses are taken. Throughput is set by the single update of the timer
// state per cycle. A stalled response stops the update; the input register
// still holds one more request.
// Depends on wit_pkg, wit_step and watchdog_interval_timer_assert.svh.
`default_nettype none

`include "watchdog_interval_timer_assert.svh"

module watchdog_interval_timer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [15:0] req_wdata,
   input  wire logic        req_tick_source,
   input  wire logic        req_pin_level,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [15:0] rsp_read_data,
   output      logic        rsp_irq_level,
   output      logic        rsp_nmi_pulse,
   output      logic        rsp_puc_pulse,
   output      logic        rsp_sys_reset_pulse
);

   wit_pkg::item_type   item_ff;
   wit_pkg::item_type   item_in;
   logic                item_valid_ff;
   wit_pkg::state_type  state_ff;
   wit_pkg::state_type  state_in;
   wit_pkg::result_type res_ff;
   wit_pkg::result_type res_in;
   logic                rsp_valid_ff;
   logic                advance;

   // move the held request into the output stage when it has room
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   assign item_in.cmd         = wit_pkg::cmd_type'(req_cmd);
   assign item_in.wdata       = req_wdata;
   assign item_in.tick_source = req_tick_source;
   assign item_in.pin_level   = req_pin_level;

   wit_step u_step (
      .item (item_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .res  (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '{control: 8'd0, counter: 16'd0, pin: 1'b1, irq: 1'b0};
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = res_ff.read_data;
   assign rsp_irq_level       = res_ff.irq_level;
   assign rsp_nmi_pulse       = res_ff.nmi_pulse;
   assign rsp_puc_pulse       = res_ff.puc_pulse;
   assign rsp_sys_reset_pulse = res_ff.sys_reset_pulse;

   `WIT_ASSERT_NOW(a_nmi_needs_enable, clock, reset,
      rsp_valid && rsp_nmi_pulse, state_ff.control[wit_pkg::CTL_NMI],
      "NMI response while NMI disabled")
   `WIT_ASSERT_NOW(a_sysrst_pin_low, clock, reset,
      rsp_valid && rsp_sys_reset_pulse, !state_ff.pin,
      "system reset response with pin high")
   `WIT_ASSERT_NEXT(a_ack_clears_irq, clock, reset,
      advance && item_ff.cmd == wit_pkg::CMD_ACK && state_ff.control[wit_pkg::CTL_TMSEL],
      !state_ff.irq && !rsp_irq_level,
      "acknowledge in timer mode left the flag set")
   `WIT_ASSERT_NEXT(a_hold_freezes, clock, reset,
      advance && item_ff.cmd == wit_pkg::CMD_TICK && state_ff.control[wit_pkg::CTL_HOLD],
      $stable(state_ff.counter),
      "counter moved while held")

endmodule

`default_nettype wire
